FILE: hw/rtl/srd_pkg.sv
// Shared types and constants for the sorted duplicate reporter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package srd_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_word;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    // Commands from the controller to the row of sorting cells.
    typedef struct packed {
        logic load;
        logic shift;
    } t_chain_ctrl;

    // Status from the duplicate scanner back to the controller.
    typedef struct packed {
        logic step;
        logic done;
    } t_scan_stat;

endpackage

FILE: hw/rtl/srd_cell.sv
// One cell of the insertion-sort row: holds one value and its valid bit.
// Depends on srd_pkg.
`timescale 1ns / 1ps

module srd_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic          i_shift,
    input  srd_pkg::t_word i_in,
    input  logic          i_prev_gt,
    input  srd_pkg::t_word i_prev_val,
    input  logic          i_prev_valid,
    input  srd_pkg::t_word i_next_val,
    input  logic          i_next_valid,
    output logic          o_gt,
    output srd_pkg::t_word o_val,
    output logic          o_valid
);
    import srd_pkg::*;

    t_word r_val;
    t_word n_val;
    logic  r_valid;
    logic  n_valid;

    // The new value belongs at or before this cell when the cell is empty or larger.
    assign o_gt    = !r_valid || (i_in < r_val);
    assign o_val   = r_val;
    assign o_valid = r_valid;

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        if (i_load && o_gt) begin
            if (i_prev_gt) begin
                n_val   = i_prev_val;
                n_valid = i_prev_valid;
            end else begin
                n_val   = i_in;
                n_valid = 1'b1;
            end
        end else if (i_shift) begin
            n_val   = i_next_val;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

FILE: hw/rtl/srd_chain.sv
// Row of sorting cells kept in ascending order, with the smallest value at the head.
// Depends on srd_pkg and srd_cell.
`timescale 1ns / 1ps

module srd_chain #(
    parameter int MAX_ITEMS = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srd_pkg::t_chain_ctrl i_ctrl,
    input  srd_pkg::t_word       i_in,
    output srd_pkg::t_word       o_head_val,
    output logic                o_head_valid
);
    import srd_pkg::*;

    logic  w_gt    [MAX_ITEMS];
    t_word w_val   [MAX_ITEMS];
    logic  w_valid [MAX_ITEMS];

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        logic  w_prev_gt;
        t_word w_prev_val;
        logic  w_prev_valid;
        t_word w_next_val;
        logic  w_next_valid;

        if (g == 0) begin : g_first
            assign w_prev_gt    = 1'b0;
            assign w_prev_val   = '0;
            assign w_prev_valid = 1'b0;
        end else begin : g_mid
            assign w_prev_gt    = w_gt[g-1];
            assign w_prev_val   = w_val[g-1];
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_last
            assign w_next_val   = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_val   = w_val[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        srd_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_load       (i_ctrl.load),
            .i_shift      (i_ctrl.shift),
            .i_in         (i_in),
            .i_prev_gt    (w_prev_gt),
            .i_prev_val   (w_prev_val),
            .i_prev_valid (w_prev_valid),
            .i_next_val   (w_next_val),
            .i_next_valid (w_next_valid),
            .o_gt         (w_gt[g]),
            .o_val        (w_val[g]),
            .o_valid      (w_valid[g])
        );
    end

    assign o_head_val   = w_val[0];
    assign o_head_valid = w_valid[0];

endmodule

FILE: hw/rtl/srd_dup_scan.sv
// Scans the sorted values as they leave the head of the row and drives the result stream.
// Depends on srd_pkg.
`timescale 1ns / 1ps

module srd_dup_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_active,
    input  logic               i_head_valid,
    input  srd_pkg::t_word      i_head_val,
    input  logic               i_overflow,
    input  logic               i_m_tready,
    output srd_pkg::t_scan_stat o_stat,
    output logic               o_m_tvalid,
    output logic [31:0]        o_m_tdata,   // dup_value[31:0]
    output logic [1:0]         o_m_tuser,   // found[0], overflow[1]
    output logic               o_m_tlast    // last_result
);
    import srd_pkg::*;

    t_word r_prev;
    t_word n_prev;
    logic  r_prev_valid;
    logic  n_prev_valid;
    logic  r_reported;
    logic  n_reported;
    t_word r_pend;
    t_word n_pend;
    logic  r_pend_valid;
    logic  n_pend_valid;

    logic  r_out_valid;
    logic  n_out_valid;
    t_word r_out_val;
    t_word n_out_val;
    logic  r_out_found;
    logic  n_out_found;
    logic  r_out_ovf;
    logic  n_out_ovf;
    logic  r_out_last;
    logic  n_out_last;

    logic  w_out_free;
    logic  w_is_dup;
    logic  w_push;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_is_dup   = i_head_valid && r_prev_valid && (i_head_val == r_prev) && !r_reported;

    always_comb begin
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        n_reported   = r_reported;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_val    = r_out_val;
        n_out_found  = r_out_found;
        n_out_ovf    = r_out_ovf;
        n_out_last   = r_out_last;
        o_stat       = '0;
        w_push       = 1'b0;

        if (i_active) begin
            if (i_head_valid) begin
                // A new duplicate pushes out the one held back, which is then known not to be last.
                w_push      = w_is_dup && r_pend_valid;
                o_stat.step = !w_push || w_out_free;
                if (o_stat.step) begin
                    if (w_is_dup) begin
                        n_pend       = i_head_val;
                        n_pend_valid = 1'b1;
                        n_reported   = 1'b1;
                    end else if (!r_prev_valid || (i_head_val != r_prev)) begin
                        n_reported = 1'b0;
                    end
                    n_prev       = i_head_val;
                    n_prev_valid = 1'b1;
                    if (w_push) begin
                        n_out_valid = 1'b1;
                        n_out_val   = r_pend;
                        n_out_found = 1'b1;
                        n_out_ovf   = i_overflow;
                        n_out_last  = 1'b0;
                    end
                end
            end else begin
                // Row is empty: emit the held duplicate as the last one, or the empty report.
                w_push      = 1'b1;
                o_stat.step = w_out_free;
                o_stat.done = w_out_free;
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_val    = r_pend_valid ? r_pend : '0;
                    n_out_found  = r_pend_valid;
                    n_out_ovf    = i_overflow;
                    n_out_last   = 1'b1;
                    n_prev_valid = 1'b0;
                    n_reported   = 1'b0;
                    n_pend_valid = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev      <= n_prev;
        r_pend      <= n_pend;
        r_out_val   <= n_out_val;
        r_out_found <= n_out_found;
        r_out_ovf   <= n_out_ovf;
        r_out_last  <= n_out_last;
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
            r_reported   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_prev_valid <= n_prev_valid;
            r_reported   <= n_reported;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_val;
    assign o_m_tuser  = {r_out_ovf, r_out_found};
    assign o_m_tlast  = r_out_last;

endmodule

FILE: hw/rtl/sort_and_report_duplicates.sv
// Top level of the sorted duplicate reporter: load control, sorting row and result scanner.
// Depends on srd_pkg, srd_chain and srd_dup_scan.
//
//  Channel  Dir  Fields                               Handshake
//  s_axis   in   tdata=value, tlast=final_item        tvalid/tready
//  m_axis   out  tdata=dup_value, tuser={ovf,found},  tvalid/tready
//                tlast=last_result
//
// Loading takes one transaction per cycle; each value is inserted into the row of
// cells in the cycle it arrives, so the set is sorted when its final item lands.
// Values that find the row full are dropped and set the overflow flag. Draining
// shifts the row towards the head one cell per cycle, except while the output stalls.
// Input is refused during draining. Reset empties the row and clears all counters.
`timescale 1ns / 1ps

module sort_and_report_duplicates #(
    parameter int MAX_ITEMS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    input  logic        s_axis_tlast,   // final_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // dup_value[31:0]
    output logic [1:0]  m_axis_tuser,   // found[0], overflow[1]
    output logic        m_axis_tlast    // last_result
);
    import srd_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    t_state      r_state;
    t_state      n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic        r_dropped;
    logic        n_dropped;

    t_chain_ctrl w_ctrl;
    t_scan_stat  w_stat;
    t_word       w_head_val;
    logic        w_head_valid;
    logic        w_accept;
    logic        w_room;

    assign s_axis_tready = (r_state == ST_LOAD);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_room        = (r_count < CNT_W'(MAX_ITEMS));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_dropped    = r_dropped;
        w_ctrl       = '0;
        case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (w_room) begin
                        w_ctrl.load = 1'b1;
                        n_count     = r_count + 1'b1;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                w_ctrl.shift = w_stat.step && w_head_valid;
                if (w_stat.done) begin
                    n_state   = ST_LOAD;
                    n_count   = '0;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    srd_chain #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_in         (t_word'(s_axis_tdata)),
        .o_head_val   (w_head_val),
        .o_head_valid (w_head_valid)
    );

    srd_dup_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_active     (r_state == ST_DRAIN),
        .i_head_valid (w_head_valid),
        .i_head_val   (w_head_val),
        .i_overflow   (r_dropped),
        .i_m_tready   (m_axis_tready),
        .o_stat       (w_stat),
        .o_m_tvalid   (m_axis_tvalid),
        .o_m_tdata    (m_axis_tdata),
        .o_m_tuser    (m_axis_tuser),
        .o_m_tlast    (m_axis_tlast)
    );

endmodule
